// ===== design/mcrs_pkg.sv =====
// ----------------------------------------------------------------------------
// mcrs_pkg
// Shared types and constants of the multi-channel relay scheduler.
// ----------------------------------------------------------------------------
package mcrs_pkg;

  localparam int CHANNELS = 4;
  localparam int REPORTED = 4;
  localparam int NREP     = (CHANNELS < REPORTED) ? CHANNELS : REPORTED;

  localparam int REQ_W   = 3;
  localparam int NOW_W   = 32;
  localparam int MIN_W   = 15;
  localparam int SEC_W   = 16;

  // largest finite time is below 2**33; all ones marks a channel that never ends
  localparam int MS_W    = 33;
  localparam int MINMS_W = 31;
  localparam int MS_PER_MIN = 60000;

  // remaining ms at or above this saturate the seconds count
  localparam int SAT_MS  = 65536 * 1000;
  localparam int DIFF_W  = 26;
  localparam int Y_W     = DIFF_W - 3;

  // floor(x / 1000) = floor((x >> 3) / 125) = ((x >> 3) * RECIP) >> RECIP_SHIFT
  localparam int RECIP_SHIFT = 30;
  localparam int RECIP_W     = 24;
  localparam int RECIP       = ((1 << RECIP_SHIFT) + 124) / 125;
  localparam int PROD_W      = Y_W + RECIP_W;

  typedef enum logic [1:0] {
    ST_OFF    = 2'd0,
    ST_WAIT   = 2'd1,
    ST_TIMING = 2'd2
  } chan_state_t;

  typedef enum logic [REQ_W-1:0] {
    REQ_TICK     = 3'd0,
    REQ_ALL_ON   = 3'd1,
    REQ_ALL_OFF  = 3'd2,
    REQ_MASK_ON  = 3'd3,
    REQ_MASK_OFF = 3'd4
  } req_t;

  typedef logic [MS_W-1:0] ms_t;

endpackage

// ===== design/mcrs_req_if.sv =====
// ----------------------------------------------------------------------------
// mcrs_req_if
// Request channel: tick time and optional command, valid/ready handshake.
// ----------------------------------------------------------------------------
interface mcrs_req_if;
  logic                          valid;
  logic                          ready;
  logic [mcrs_pkg::REQ_W-1:0]    req_type;
  logic [mcrs_pkg::NOW_W-1:0]    now_ms;
  logic [mcrs_pkg::REPORTED-1:0] chan_select;
  logic [mcrs_pkg::MIN_W-1:0]    delay_min;
  logic [mcrs_pkg::MIN_W-1:0]    duration_min;

  modport source (
    output valid, req_type, now_ms, chan_select, delay_min, duration_min,
    input  ready
  );
  modport sink (
    input  valid, req_type, now_ms, chan_select, delay_min, duration_min,
    output ready
  );
endinterface

// ===== design/mcrs_res_if.sv =====
// ----------------------------------------------------------------------------
// mcrs_res_if
// Result channel: relay and state masks with remaining seconds per channel.
// ----------------------------------------------------------------------------
interface mcrs_res_if;
  logic                          valid;
  logic                          ready;
  logic [mcrs_pkg::REPORTED-1:0] relay_mask;
  logic [mcrs_pkg::REPORTED-1:0] waiting_mask;
  logic [mcrs_pkg::REPORTED-1:0] timing_mask;
  logic [mcrs_pkg::SEC_W-1:0]    remain_sec_0;
  logic [mcrs_pkg::SEC_W-1:0]    remain_sec_1;
  logic [mcrs_pkg::SEC_W-1:0]    remain_sec_2;
  logic [mcrs_pkg::SEC_W-1:0]    remain_sec_3;

  modport source (
    output valid, relay_mask, waiting_mask, timing_mask,
           remain_sec_0, remain_sec_1, remain_sec_2, remain_sec_3,
    input  ready
  );
  modport sink (
    input  valid, relay_mask, waiting_mask, timing_mask,
           remain_sec_0, remain_sec_1, remain_sec_2, remain_sec_3,
    output ready
  );
endinterface

// ===== design/multi_channel_relay_scheduler.sv =====
// ----------------------------------------------------------------------------
// multi_channel_relay_scheduler
// Per-channel relay scheduling: command apply, time compare, remaining seconds.
// A request is registered in the input stage, the middle stage and the output
// stage in turn; the output stage drives its result valid on res_ch.
// Throughput: one transaction per cycle while res_ch.ready does not stall; the
// channel state updates from the input register, seconds divide in next stage.
// Reset (synchronous): all channels off, all relays open, pipeline empty.
// ----------------------------------------------------------------------------
module multi_channel_relay_scheduler (
  input  logic      clk,
  input  logic      rst,
  mcrs_req_if.sink  req_ch,
  mcrs_res_if.source res_ch
);

  // pipeline control
  logic v0, v1, v2;
  logic en0, en1, en2;

  // input stage
  mcrs_pkg::req_t                  s0_req;
  logic [mcrs_pkg::NOW_W-1:0]      s0_now;
  logic [mcrs_pkg::REPORTED-1:0]   s0_sel;
  logic [mcrs_pkg::MINMS_W-1:0]    s0_dly_ms;
  logic [mcrs_pkg::MINMS_W-1:0]    s0_dur_ms;

  // channel state
  mcrs_pkg::chan_state_t           chan_state [mcrs_pkg::CHANNELS];
  mcrs_pkg::ms_t                   start_at   [mcrs_pkg::CHANNELS];
  mcrs_pkg::ms_t                   stop_at    [mcrs_pkg::CHANNELS];
  logic [mcrs_pkg::CHANNELS-1:0]   relay_closed;

  mcrs_pkg::chan_state_t           chan_state_next [mcrs_pkg::CHANNELS];
  mcrs_pkg::ms_t                   start_at_next   [mcrs_pkg::CHANNELS];
  mcrs_pkg::ms_t                   stop_at_next    [mcrs_pkg::CHANNELS];
  logic [mcrs_pkg::CHANNELS-1:0]   relay_closed_next;

  // middle stage
  logic [mcrs_pkg::REPORTED-1:0]   s1_relay, s1_wait, s1_timing, s1_sat;
  logic [mcrs_pkg::Y_W-1:0]        s1_y [mcrs_pkg::REPORTED];

  logic [mcrs_pkg::REPORTED-1:0]   s1_relay_next, s1_wait_next, s1_timing_next;
  logic [mcrs_pkg::REPORTED-1:0]   s1_sat_next;
  logic [mcrs_pkg::Y_W-1:0]        s1_y_next [mcrs_pkg::REPORTED];

  // output stage
  logic [mcrs_pkg::REPORTED-1:0]   o_relay, o_wait, o_timing;
  logic [mcrs_pkg::SEC_W-1:0]      o_sec [mcrs_pkg::REPORTED];
  logic [mcrs_pkg::SEC_W-1:0]      o_sec_next [mcrs_pkg::REPORTED];

  mcrs_pkg::ms_t                   now_ext, start_calc, stop_calc, diff;
  logic [mcrs_pkg::CHANNELS-1:0]   picked;
  logic [mcrs_pkg::CHANNELS-1:0]   off_vec;
  logic [mcrs_pkg::PROD_W-1:0]     prod [mcrs_pkg::REPORTED];

  assign en2 = !v2 || res_ch.ready;
  assign en1 = !v1 || en2;
  assign en0 = !v0 || en1;
  assign req_ch.ready = en0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (en0) v0 <= req_ch.valid;
      if (en1) v1 <= v0;
      if (en2) v2 <= v1;
    end
  end

  // capture request, scale minutes to ms
  always_ff @(posedge clk) begin
    if (en0 && req_ch.valid) begin
      s0_req    <= mcrs_pkg::req_t'(req_ch.req_type);
      s0_now    <= req_ch.now_ms;
      s0_sel    <= req_ch.chan_select;
      s0_dly_ms <= mcrs_pkg::MINMS_W'(req_ch.delay_min)
                   * mcrs_pkg::MINMS_W'(mcrs_pkg::MS_PER_MIN);
      s0_dur_ms <= mcrs_pkg::MINMS_W'(req_ch.duration_min)
                   * mcrs_pkg::MINMS_W'(mcrs_pkg::MS_PER_MIN);
    end
  end

  always_comb begin
    now_ext    = mcrs_pkg::MS_W'(s0_now);
    start_calc = now_ext + mcrs_pkg::MS_W'(s0_dly_ms);
    stop_calc  = start_calc + mcrs_pkg::MS_W'(s0_dur_ms);
    picked     = '0;
    for (int k = 0; k < mcrs_pkg::NREP; k++) begin
      picked[k] = s0_sel[k];
    end

    relay_closed_next = relay_closed;
    for (int k = 0; k < mcrs_pkg::CHANNELS; k++) begin
      chan_state_next[k] = chan_state[k];
      start_at_next[k]   = start_at[k];
      stop_at_next[k]    = stop_at[k];

      // apply command
      case (s0_req)
        mcrs_pkg::REQ_ALL_ON: begin
          chan_state_next[k] = mcrs_pkg::ST_WAIT;
          start_at_next[k]   = now_ext;
          stop_at_next[k]    = '1;
        end
        mcrs_pkg::REQ_ALL_OFF: begin
          chan_state_next[k] = mcrs_pkg::ST_TIMING;
          start_at_next[k]   = now_ext;
          stop_at_next[k]    = now_ext;
        end
        mcrs_pkg::REQ_MASK_ON: begin
          if (picked[k]) begin
            chan_state_next[k] = mcrs_pkg::ST_WAIT;
            start_at_next[k]   = start_calc;
            stop_at_next[k]    = stop_calc;
          end
        end
        mcrs_pkg::REQ_MASK_OFF: begin
          if (picked[k]) begin
            chan_state_next[k] = mcrs_pkg::ST_TIMING;
            stop_at_next[k]    = '0;
          end
        end
        default: ;
      endcase

      // compare with time
      case (chan_state_next[k])
        mcrs_pkg::ST_WAIT: begin
          if (now_ext > start_at_next[k]) begin
            relay_closed_next[k] = 1'b1;
            chan_state_next[k]   = mcrs_pkg::ST_TIMING;
          end
        end
        mcrs_pkg::ST_TIMING: begin
          if (now_ext > stop_at_next[k]) begin
            relay_closed_next[k] = 1'b0;
            chan_state_next[k]   = mcrs_pkg::ST_OFF;
          end
        end
        default: ;
      endcase
    end

    s1_relay_next  = '0;
    s1_wait_next   = '0;
    s1_timing_next = '0;
    s1_sat_next    = '0;
    diff           = '0;
    for (int k = 0; k < mcrs_pkg::REPORTED; k++) begin
      s1_y_next[k] = '0;
    end
    for (int k = 0; k < mcrs_pkg::NREP; k++) begin
      s1_relay_next[k]  = relay_closed_next[k];
      s1_wait_next[k]   = (chan_state_next[k] == mcrs_pkg::ST_WAIT);
      s1_timing_next[k] = (chan_state_next[k] == mcrs_pkg::ST_TIMING);
      if (s1_timing_next[k] && (stop_at_next[k] > now_ext)) begin
        diff = stop_at_next[k] - now_ext;
        if (diff >= mcrs_pkg::MS_W'(mcrs_pkg::SAT_MS)) begin
          s1_sat_next[k] = 1'b1;
        end else begin
          s1_y_next[k] = diff[mcrs_pkg::DIFF_W-1:3];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < mcrs_pkg::CHANNELS; k++) begin
        chan_state[k] <= mcrs_pkg::ST_OFF;
      end
      relay_closed <= '0;
    end else if (en1 && v0) begin
      for (int k = 0; k < mcrs_pkg::CHANNELS; k++) begin
        chan_state[k] <= chan_state_next[k];
      end
      relay_closed <= relay_closed_next;
    end
  end

  always_ff @(posedge clk) begin
    if (en1 && v0) begin
      for (int k = 0; k < mcrs_pkg::CHANNELS; k++) begin
        start_at[k] <= start_at_next[k];
        stop_at[k]  <= stop_at_next[k];
      end
      s1_relay  <= s1_relay_next;
      s1_wait   <= s1_wait_next;
      s1_timing <= s1_timing_next;
      s1_sat    <= s1_sat_next;
      for (int k = 0; k < mcrs_pkg::REPORTED; k++) begin
        s1_y[k] <= s1_y_next[k];
      end
    end
  end

  // divide remaining ms by 1000 through reciprocal multiply
  always_comb begin
    for (int k = 0; k < mcrs_pkg::REPORTED; k++) begin
      prod[k] = mcrs_pkg::PROD_W'(s1_y[k])
                * mcrs_pkg::PROD_W'(mcrs_pkg::RECIP);
      if (s1_sat[k]) begin
        o_sec_next[k] = '1;
      end else begin
        o_sec_next[k] = prod[k][mcrs_pkg::RECIP_SHIFT +: mcrs_pkg::SEC_W];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en2 && v1) begin
      o_relay  <= s1_relay;
      o_wait   <= s1_wait;
      o_timing <= s1_timing;
      for (int k = 0; k < mcrs_pkg::REPORTED; k++) begin
        o_sec[k] <= o_sec_next[k];
      end
    end
  end

  assign res_ch.valid        = v2;
  assign res_ch.relay_mask   = o_relay;
  assign res_ch.waiting_mask = o_wait;
  assign res_ch.timing_mask  = o_timing;
  assign res_ch.remain_sec_0 = o_sec[0];
  assign res_ch.remain_sec_1 = o_sec[1];
  assign res_ch.remain_sec_2 = o_sec[2];
  assign res_ch.remain_sec_3 = o_sec[3];

  always_comb begin
    for (int k = 0; k < mcrs_pkg::CHANNELS; k++) begin
      off_vec[k] = (chan_state[k] == mcrs_pkg::ST_OFF);
    end
  end

  a_off_relay_open: assert property (@(posedge clk) disable iff (rst)
    (off_vec & relay_closed) == '0)
    else $error("relay closed on a channel that is off");

  a_wait_timing_disjoint: assert property (@(posedge clk) disable iff (rst)
    res_ch.valid |-> (res_ch.waiting_mask & res_ch.timing_mask) == '0)
    else $error("channel reported both waiting and timing");

  a_remain_only_timing: assert property (@(posedge clk) disable iff (rst)
    res_ch.valid |-> ((res_ch.remain_sec_0 == '0 || res_ch.timing_mask[0])
                   && (res_ch.remain_sec_1 == '0 || res_ch.timing_mask[1])
                   && (res_ch.remain_sec_2 == '0 || res_ch.timing_mask[2])
                   && (res_ch.remain_sec_3 == '0 || res_ch.timing_mask[3])))
    else $error("remaining seconds on a channel that is not timing");

  a_stage_advance: assert property (@(posedge clk) disable iff (rst)
    (v1 && en2) |=> v2)
    else $error("middle stage transaction lost");

endmodule
